### rtl/core/mms_pkg.sv
// ----------------------------------------------------------------------------
// mms_pkg: shared types and constants for the media magic-signature scanner
// Signature byte tables, format codes and the match result struct.
// ----------------------------------------------------------------------------
package mms_pkg;

  localparam int SigCount  = 7;
  localparam int SigSpan   = 12;  // bytes of the window that the signatures look at
  localparam int TailAt    = 8;   // offset of the second four-byte tag
  localparam int OutOffW   = 32;  // width of the start_offset port
  localparam int TotalW    = 32;  // width of the match total

  typedef enum logic [2:0] {
    FMT_GIF  = 3'd0,
    FMT_PNG  = 3'd1,
    FMT_JPEG = 3'd2,
    FMT_WAVE = 3'd3,
    FMT_MIDI = 3'd4,
    FMT_AU   = 3'd5,
    FMT_AIFF = 3'd6
  } fmt_e;

  typedef struct packed {
    logic hit;
    fmt_e fmt;
  } match_t;

  // Byte 0 of each tag sits in bits [31:24].
  localparam logic [31:0] SIG_HEAD [SigCount] = '{
    32'h4749_4600,  // GIF
    32'h8950_4E47,  // PNG
    32'hFFD8_FF00,  // JPEG
    32'h5249_4646,  // RIFF
    32'h4D54_6864,  // MThd
    32'h2E73_6E64,  // .snd
    32'h464F_524D   // FORM
  };

  localparam logic [2:0] SIG_HEAD_LEN [SigCount] = '{
    3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4
  };

  localparam logic SIG_HAS_TAIL [SigCount] = '{
    1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1
  };

  localparam logic [31:0] SIG_TAIL [SigCount] = '{
    32'h0, 32'h0, 32'h0,
    32'h5741_5645,  // WAVE
    32'h0, 32'h0,
    32'h4149_4646   // AIFF
  };

endpackage

### rtl/core/mms_window.sv
// ----------------------------------------------------------------------------
// mms_window: byte window, fill count and range position
// Shifts one byte in per transfer and presents the updated view.
// ----------------------------------------------------------------------------
module mms_window import mms_pkg::*; #(
  parameter int WINDOW_LEN  = 12,
  parameter int OFFSET_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   shift_i,
  input  logic [7:0]             byte_i,
  input  logic                   first_i,
  output logic [7:0]             sig_win_o [SigSpan],
  output logic                   full_o,
  output logic [OFFSET_BITS-1:0] pos_o
);

  localparam int FillW = $clog2(WINDOW_LEN + 1);

  logic [7:0]             win_q [WINDOW_LEN];
  logic [7:0]             win_d [WINDOW_LEN];
  logic [FillW-1:0]       fill_q, fill_d, fill_base;
  logic [OFFSET_BITS-1:0] pos_q, pos_d, pos_base;

  always_comb begin
    for (int i = 0; i < WINDOW_LEN - 1; i++) begin
      win_d[i] = win_q[i+1];
    end
    win_d[WINDOW_LEN-1] = byte_i;
  end

  // A range start restarts fill and position before the byte counts.
  assign fill_base = first_i ? '0 : fill_q;
  assign fill_d    = (fill_base == FillW'(WINDOW_LEN)) ? fill_base : fill_base + 1'b1;
  assign pos_base  = first_i ? '0 : pos_q;
  assign pos_d     = (&pos_base) ? pos_base : pos_base + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      pos_q  <= '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_q[i] <= '0;
      end
    end else if (shift_i) begin
      fill_q <= fill_d;
      pos_q  <= pos_d;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_q[i] <= win_d[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < SigSpan; i++) begin
      sig_win_o[i] = win_d[i];
    end
  end

  assign full_o = (fill_d == FillW'(WINDOW_LEN));
  assign pos_o  = pos_d;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(WINDOW_LEN))
    else $error("fill count beyond window length");
`endif

endmodule

### rtl/core/mms_match.sv
// ----------------------------------------------------------------------------
// mms_match: signature comparators and priority pick
// Tests the oldest window position against all tags, first hit wins.
// ----------------------------------------------------------------------------
module mms_match import mms_pkg::*; (
  input  logic [7:0] win_i [SigSpan],
  output match_t     match_o
);

  logic [SigCount-1:0] hits;

  always_comb begin
    for (int s = 0; s < SigCount; s++) begin
      hits[s] = 1'b1;
      for (int j = 0; j < 4; j++) begin
        if (3'(j) < SIG_HEAD_LEN[s] && win_i[j] != SIG_HEAD[s][31-8*j -: 8]) begin
          hits[s] = 1'b0;
        end
        if (SIG_HAS_TAIL[s] && win_i[TailAt+j] != SIG_TAIL[s][31-8*j -: 8]) begin
          hits[s] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    match_o.hit = 1'b0;
    match_o.fmt = FMT_GIF;
    for (int s = SigCount - 1; s >= 0; s--) begin
      if (hits[s]) begin
        match_o.hit = 1'b1;
        match_o.fmt = fmt_e'(3'(s));
      end
    end
  end

endmodule

### rtl/core/media_magic_signature_scanner.sv
// ----------------------------------------------------------------------------
// media_magic_signature_scanner: streaming file-magic detector
// Scans a byte stream for GIF, PNG, JPEG, WAVE, MIDI, AU and AIFF headers.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake               | Payload
//  --------+-------------------------+------------------------------------------
//  in      | in_valid_i / in_ready_o | data_byte_i, range_first_i
//  out     | out_valid_o/out_ready_i | match_found_o, format_code_o,
//          |                         | start_offset_o, match_total_o
//
//  One result per input transfer. Throughput is one byte per cycle while the
//  output does not stall; each byte passes the input register, then the
//  result register. The window shift, comparators and match counter update
//  are combinational between the input register and the result register.
//  Reset clears the window, fill count, position, match total and both valid
//  flags. When the output stalls, the input register still holds one byte,
//  after which in_ready_o drops until the result is taken.
//
module media_magic_signature_scanner import mms_pkg::*; #(
  parameter int WINDOW_LEN  = 12,
  parameter int OFFSET_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               range_first_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               match_found_o,
  output logic [2:0]         format_code_o,
  output logic [OutOffW-1:0] start_offset_o,
  output logic [TotalW-1:0]  match_total_o
);

  // Input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_first_q;
  logic       advance;

  // Scan datapath
  logic [7:0]             sig_win [SigSpan];
  logic                   win_full;
  logic [OFFSET_BITS-1:0] pos_next;
  logic [OFFSET_BITS-1:0] start_full;
  logic [OutOffW-1:0]     start_out;
  match_t                 match;
  logic                   hit;

  // Match total
  logic [TotalW-1:0] match_cnt_q, match_cnt_d;

  // Result register
  logic               out_valid_q;
  logic               found_q;
  fmt_e               fmt_q;
  logic [OutOffW-1:0] start_q;

  // The input stage moves forward whenever the result register is free
  // or being emptied this cycle.
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q  <= data_byte_i;
      s1_first_q <= range_first_i;
    end
  end

  mms_window #(
    .WINDOW_LEN  (WINDOW_LEN),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .shift_i   (advance),
    .byte_i    (s1_byte_q),
    .first_i   (s1_first_q),
    .sig_win_o (sig_win),
    .full_o    (win_full),
    .pos_o     (pos_next)
  );

  mms_match u_match (
    .win_i   (sig_win),
    .match_o (match)
  );

  // Only a full window is tested; the oldest byte sits WINDOW_LEN back.
  assign hit        = win_full && match.hit;
  assign start_full = pos_next - OFFSET_BITS'(WINDOW_LEN);

  if (OFFSET_BITS >= OutOffW) begin : g_off_trunc
    assign start_out = start_full[OutOffW-1:0];
  end else begin : g_off_ext
    assign start_out = {{(OutOffW - OFFSET_BITS){1'b0}}, start_full};
  end

  // Saturating match total, includes the hit of this transfer.
  assign match_cnt_d = (hit && !(&match_cnt_q)) ? match_cnt_q + 1'b1 : match_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        match_cnt_q <= match_cnt_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      found_q <= hit;
      fmt_q   <= hit ? match.fmt : FMT_GIF;
      start_q <= win_full ? start_out : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign match_found_o  = found_q;
  assign format_code_o  = fmt_q;
  assign start_offset_o = start_q;
  assign match_total_o  = match_cnt_q;

`ifndef NO_ASSERTIONS
  a_found_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && found_q |-> match_cnt_q != '0)
    else $error("match reported with zero match total");

  a_nomatch_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !found_q |-> fmt_q == FMT_GIF)
    else $error("format code set without a match");

  a_total_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    match_cnt_q >= $past(match_cnt_q))
    else $error("match total decreased");
`endif

endmodule

### tb/sv/media_magic_signature_scanner_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// media_magic_signature_scanner_test: self-checking bench for the magic scanner
// A directed table, then well-formed signature streams mixed with noise.
// Every byte transfer is predicted in-bench and every result is compared.
// ----------------------------------------------------------------------------
module media_magic_signature_scanner_test import mms_pkg::*;;

  localparam int WIN_LEN      = 12;   // scan window length of the DUT
  localparam int TAIL_POS     = 8;    // where RIFF/FORM carry their second tag
  localparam int FMT_COUNT    = 7;
  localparam int RANDOM_ITEMS = 2000;
  localparam int PRESSURE_AT  = 900;  // byte count that triggers the long hold-off
  localparam int PRESSURE_LEN = 250;  // cycles the receiver holds ready low
  localparam int DRAIN_LIMIT  = 20000;

  // Pacing of both sides, changed per burst.
  typedef enum logic [1:0] {
    PACE_CALM,
    PACE_LIGHT,
    PACE_HEAVY
  } pace_e;

  // One result transfer.
  typedef struct packed {
    logic              found;
    fmt_e              fmt;
    logic [OutOffW-1:0] ofs;
    logic [TotalW-1:0]  total;
  } scan_result_t;

  // One row of the directed table. Typed rows carry their own result;
  // the rest are checked against the predictor.
  typedef struct packed {
    logic [7:0]   data;
    logic         first;
    logic         typed;
    scan_result_t want;
  } plan_row_t;

  // Window not yet full: all zero except the running total.
  localparam scan_result_t NOT_FULL_T0 = '{1'b0, FMT_GIF, 32'd0, 32'd0};
  localparam scan_result_t NOT_FULL_T1 = '{1'b0, FMT_GIF, 32'd0, 32'd1};

  localparam int PLAN_ROWS = 27;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // GIF header right at the start of the first range
    '{8'h47, 1'b1, 1'b1, NOT_FULL_T0},
    '{8'h49, 1'b0, 1'b1, NOT_FULL_T0},
    '{8'h46, 1'b0, 1'b1, NOT_FULL_T0},
    '{8'hFF, 1'b0, 1'b0, NOT_FULL_T0},
    '{8'h00, 1'b0, 1'b0, NOT_FULL_T0},
    '{8'hFF, 1'b0, 1'b0, NOT_FULL_T0},
    '{8'h00, 1'b0, 1'b0, NOT_FULL_T0},
    '{8'hFF, 1'b0, 1'b0, NOT_FULL_T0},
    '{8'h00, 1'b0, 1'b0, NOT_FULL_T0},
    '{8'hFF, 1'b0, 1'b0, NOT_FULL_T0},
    '{8'h00, 1'b0, 1'b1, NOT_FULL_T0},
    '{8'hFF, 1'b0, 1'b1, '{1'b1, FMT_GIF, 32'd0, 32'd1}},
    // full window, no signature at offset 1
    '{8'h00, 1'b0, 1'b0, NOT_FULL_T0},
    // range restart mid-stream, then again with a partly filled window
    '{8'h00, 1'b1, 1'b1, NOT_FULL_T1},
    '{8'hFF, 1'b0, 1'b1, NOT_FULL_T1},
    '{8'h89, 1'b1, 1'b1, NOT_FULL_T1},
    '{8'h50, 1'b0, 1'b0, NOT_FULL_T0},
    '{8'h4E, 1'b0, 1'b0, NOT_FULL_T0},
    '{8'h47, 1'b0, 1'b0, NOT_FULL_T0},
    '{8'hFF, 1'b0, 1'b0, NOT_FULL_T0},
    '{8'h00, 1'b0, 1'b0, NOT_FULL_T0},
    '{8'h80, 1'b0, 1'b0, NOT_FULL_T0},
    '{8'h7F, 1'b0, 1'b0, NOT_FULL_T0},
    '{8'h01, 1'b0, 1'b0, NOT_FULL_T0},
    '{8'hFE, 1'b0, 1'b0, NOT_FULL_T0},
    '{8'h55, 1'b0, 1'b1, NOT_FULL_T1},
    '{8'hAA, 1'b0, 1'b1, '{1'b1, FMT_PNG, 32'd0, 32'd2}}
  };

  // Bench copy of the signature bytes, indexed by format code.
  localparam logic [7:0] MAGIC_HEAD [FMT_COUNT][4] = '{
    '{8'h47, 8'h49, 8'h46, 8'h00},
    '{8'h89, 8'h50, 8'h4E, 8'h47},
    '{8'hFF, 8'hD8, 8'hFF, 8'h00},
    '{8'h52, 8'h49, 8'h46, 8'h46},
    '{8'h4D, 8'h54, 8'h68, 8'h64},
    '{8'h2E, 8'h73, 8'h6E, 8'h64},
    '{8'h46, 8'h4F, 8'h52, 8'h4D}
  };
  localparam int MAGIC_LEN [FMT_COUNT] = '{3, 4, 3, 4, 4, 4, 4};
  localparam logic MAGIC_TAILED [FMT_COUNT] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
  localparam logic [7:0] MAGIC_TAIL [FMT_COUNT][4] = '{
    '{8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h57, 8'h41, 8'h56, 8'h45},
    '{8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h41, 8'h49, 8'h46, 8'h46}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [7:0]         data_byte_i;
  logic               range_first_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               match_found_o;
  logic [2:0]         format_code_o;
  logic [OutOffW-1:0] start_offset_o;
  logic [TotalW-1:0]  match_total_o;

  // Predictor state: window, fill, position in range, match tally.
  logic [7:0]  win_bytes [WIN_LEN];
  int unsigned win_fill;
  logic [31:0] range_pos;
  logic [31:0] hit_tally;

  scan_result_t pending_results [$];
  logic [8:0]   burst [$];        // {range_first, data_byte} per byte
  int unsigned  bytes_sent;
  int unsigned  mismatches;
  pace_e        pace;
  bit           pressure_done;

  media_magic_signature_scanner #(
    .WINDOW_LEN (WIN_LEN),
    .OFFSET_BITS(32)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .range_first_i (range_first_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .match_found_o (match_found_o),
    .format_code_o (format_code_o),
    .start_offset_o(start_offset_o),
    .match_total_o (match_total_o)
  );

  initial begin
    clk_i = 1'b0;
  end
  always #5 clk_i = ~clk_i;

  // Advance the scan state by one byte and return the result it yields.
  function automatic scan_result_t scan_next_byte(logic [7:0] b, logic first);
    scan_result_t r;
    logic         hit;
    r = '0;
    if (first) begin
      win_fill  = 0;
      range_pos = '0;
    end
    for (int i = 0; i < WIN_LEN - 1; i++) win_bytes[i] = win_bytes[i + 1];
    win_bytes[WIN_LEN - 1] = b;
    if (win_fill < WIN_LEN) win_fill++;
    if (range_pos != '1) range_pos++;
    // Only a full window tests its oldest byte; first hit in priority order wins.
    if (win_fill == WIN_LEN) begin
      r.ofs = range_pos - WIN_LEN;
      for (int k = 0; k < FMT_COUNT && !r.found; k++) begin
        hit = 1'b1;
        for (int j = 0; j < MAGIC_LEN[k]; j++) begin
          if (win_bytes[j] != MAGIC_HEAD[k][j]) hit = 1'b0;
        end
        if (MAGIC_TAILED[k]) begin
          for (int j = 0; j < 4; j++) begin
            if (win_bytes[TAIL_POS + j] != MAGIC_TAIL[k][j]) hit = 1'b0;
          end
        end
        if (hit) begin
          r.found = 1'b1;
          r.fmt   = fmt_e'(k);
          if (hit_tally != '1) hit_tally++;
        end
      end
    end
    r.total = hit_tally;
    return r;
  endfunction

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (pace)
      PACE_CALM: return 0;
      PACE_LIGHT: begin
        if (roll < 80) return 0;
        if (roll < 97) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
      end
      default: begin
        if (roll < 50) return 0;
        if (roll < 90) return $urandom_range(1, 4);
        return $urandom_range(5, 30);
      end
    endcase
  endfunction

  // Offer one byte at a falling edge, after an optional idle gap, and hold it until the transfer.
  task automatic send_byte(logic [7:0] b, logic first, logic typed, scan_result_t want);
    int unsigned  gap;
    scan_result_t predicted;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    data_byte_i   <= b;
    range_first_i <= first;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = scan_next_byte(b, first);
    pending_results.push_back(typed ? want : predicted);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Queue a signature at the window's head position, optionally with one
  // significant byte broken so that it must not match.
  task automatic queue_signature(int k, bit broken, bit new_range);
    int unsigned base;
    int unsigned spot;
    base = burst.size();
    for (int j = 0; j < MAGIC_LEN[k]; j++) burst.push_back({1'b0, MAGIC_HEAD[k][j]});
    if (MAGIC_TAILED[k]) begin
      for (int j = 0; j < TAIL_POS - 4; j++) burst.push_back({1'b0, 8'($urandom)});
      for (int j = 0; j < 4; j++) burst.push_back({1'b0, MAGIC_TAIL[k][j]});
    end
    if (broken) begin
      // pick a byte of the head, or of the tail tag
      spot = $urandom_range(0, MAGIC_TAILED[k] ? 7 : MAGIC_LEN[k] - 1);
      if (spot >= 4) spot = spot + TAIL_POS - 4;
      burst[base + spot][7:0] = burst[base + spot][7:0] ^ 8'($urandom_range(1, 255));
    end
    burst[base][8] = new_range;
  endtask

  // Queue filler: plain random bytes or bytes drawn from the signature tags.
  task automatic queue_filler(int unsigned len, bit tag_bytes);
    logic [7:0] b;
    for (int unsigned n = 0; n < len; n++) begin
      if (tag_bytes) begin
        b = ($urandom_range(0, 1) != 0) ? MAGIC_HEAD[$urandom_range(0, FMT_COUNT - 1)]
                                                   [$urandom_range(0, 3)]
                                        : MAGIC_TAIL[$urandom_range(0, FMT_COUNT - 1)]
                                                    [$urandom_range(0, 3)];
      end else begin
        b = 8'($urandom);
      end
      burst.push_back({($urandom_range(0, 99) < 3), b});
    end
  endtask

  task automatic send_burst();
    logic [8:0] item;
    while (burst.size() != 0) begin
      item = burst.pop_front();
      send_byte(item[7:0], item[8], 1'b0, '0);
    end
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Result checker: every output transfer against the oldest expectation.
  always @(posedge clk_i) begin
    scan_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        compare_field("match_found", 32'(want.found), 32'(match_found_o));
        compare_field("format_code", 32'(want.fmt), 32'(format_code_o));
        compare_field("start_offset", want.ofs, start_offset_o);
        compare_field("match_total", want.total, match_total_o);
      end
    end
  end

  // Receiver: random ready, plus one long hold-off so the DUT backs up
  // and drops in_ready_o while the sender keeps offering.
  initial begin : result_sink
    int unsigned hold;
    hold        = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!pressure_done && bytes_sent >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        hold          = PRESSURE_LEN;
      end
      if (hold != 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else begin
        hold = pick_gap();
        out_ready_i <= (hold == 0);
      end
    end
  end

  // Hard limit on run time.
  initial begin
    #5_000_000;
    $display("media_magic_signature_scanner_test failed");
    $finish;
  end

  initial begin : stimulus
    int          roll;
    int unsigned waited;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    data_byte_i   = '0;
    range_first_i = 1'b0;
    bytes_sent    = 0;
    mismatches    = 0;
    pressure_done = 1'b0;
    pace          = PACE_LIGHT;
    win_fill      = 0;
    range_pos     = '0;
    hit_tally     = '0;
    for (int i = 0; i < WIN_LEN; i++) win_bytes[i] = '0;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table.
    for (int r = 0; r < PLAN_ROWS; r++) begin
      send_byte(PLAN[r].data, PLAN[r].first, PLAN[r].typed, PLAN[r].want);
    end

    // Every format once as a clean stream, trailed by enough filler to test it.
    for (int k = 0; k < FMT_COUNT; k++) begin
      queue_signature(k, 1'b0, 1'b0);
      queue_filler($urandom_range(0, 5), 1'b0);
    end
    queue_filler(WIN_LEN, 1'b0);
    send_burst();

    // Random part: mostly well-formed signatures with random surroundings.
    while (bytes_sent < PLAN_ROWS + RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      pace = pace_e'(roll < 40 ? PACE_CALM : (roll < 85 ? PACE_LIGHT : PACE_HEAVY));
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        queue_signature($urandom_range(0, FMT_COUNT - 1), ($urandom_range(0, 99) < 15),
                        ($urandom_range(0, 99) < 12));
        queue_filler($urandom_range(0, 8), 1'b0);
      end else if (roll < 75) begin
        queue_filler($urandom_range(1, 20), 1'b1);
      end else if (roll < 90) begin
        queue_filler($urandom_range(1, 20), 1'b0);
      end else begin
        // short range: restart, a few bytes, restart again before it fills
        burst.push_back({1'b1, 8'($urandom)});
        queue_filler($urandom_range(0, WIN_LEN - 2), 1'b1);
        burst.push_back({1'b1, 8'($urandom)});
      end
      send_burst();
    end
    in_valid_i <= 1'b0;

    // Drain, then give the two-stage pipe time to show any stray result.
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (6) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      mismatches++;
    end

    if (mismatches == 0) begin
      $display("media_magic_signature_scanner_test passed");
    end else begin
      $display("media_magic_signature_scanner_test failed");
    end
    $finish;
  end

endmodule
